FILE: design/tfla_pkg.sv
// ----------------------------------------------------------------------------
// tfla_pkg
// Shared constants, codes, types and helper functions of the timed free-list
// slot allocator.
// ----------------------------------------------------------------------------
package tfla_pkg;

   // Pool geometry.
   localparam int POOL_SIZE = 1024;
   localparam int IDX_W     = $clog2(POOL_SIZE);
   localparam int CNT_W     = IDX_W + 1;

   // Field and register widths.
   localparam int MODE_W     = 2;
   localparam int STATUS_W   = 3;
   localparam int STAMP_W    = 64;
   localparam int DELAY_W    = 32;
   localparam int INIT_W     = 11;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 32;
   localparam int META_W     = STAMP_W + 1;

   // Smallest initial slot count.
   localparam int MIN_INITIAL = 10;

   // Stamp of a slot that was never released.
   localparam logic [STAMP_W-1:0] NEVER_RELEASED = '1;

   // Item modes.
   localparam logic [MODE_W-1:0] MODE_ACQUIRE = 2'd0;
   localparam logic [MODE_W-1:0] MODE_RELEASE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_CLOSE   = 2'd2;

   // Result status codes.
   localparam logic [STATUS_W-1:0] ST_REUSED    = 3'd0;
   localparam logic [STATUS_W-1:0] ST_CREATED   = 3'd1;
   localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 3'd2;
   localparam logic [STATUS_W-1:0] ST_CLOSED    = 3'd3;
   localparam logic [STATUS_W-1:0] ST_RELEASE   = 3'd4;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_REUSE_DELAY   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_INITIAL_SLOTS = 1'b1;

   // Write port of the clearing sweep.
   typedef struct packed {
      logic             busy;
      logic [IDX_W-1:0] addr;
      logic             queued;
   } sweep_type;

   // Raise the requested count to the minimum and cap it at the pool size.
   function automatic logic [CNT_W-1:0] clamp_initial(input logic [INIT_W-1:0] v);
      logic [CNT_W-1:0] n;
      if (32'(v) > POOL_SIZE) begin
         n = CNT_W'(POOL_SIZE);
      end else if (32'(v) < MIN_INITIAL) begin
         n = CNT_W'(MIN_INITIAL);
      end else begin
         n = CNT_W'(v);
      end
      return n;
   endfunction

   // Ring position that follows a count of n queued slots.
   function automatic logic [IDX_W-1:0] ring_pos(input logic [CNT_W-1:0] n);
      logic [IDX_W-1:0] p;
      if (n == CNT_W'(POOL_SIZE)) begin
         p = '0;
      end else begin
         p = n[IDX_W-1:0];
      end
      return p;
   endfunction

   // Step a ring pointer with wrap.
   function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] p);
      logic [IDX_W-1:0] q;
      if (p == IDX_W'(POOL_SIZE - 1)) begin
         q = '0;
      end else begin
         q = p + IDX_W'(1);
      end
      return q;
   endfunction

endpackage

FILE: design/tfla_if.sv
// ----------------------------------------------------------------------------
// tfla_req_if / tfla_rsp_if
// Valid/ready channels that carry request words into the allocator and
// response words out of it.
// ----------------------------------------------------------------------------
interface tfla_req_if;
   import tfla_pkg::*;

   logic              valid;
   logic              ready;
   logic [MODE_W-1:0] mode;
   logic [STAMP_W-1:0] now_ms;
   logic [IDX_W-1:0]  slot_index;

   modport source (output valid, output mode, output now_ms, output slot_index,
                   input ready);
   modport sink (input valid, input mode, input now_ms, input slot_index,
                 output ready);
endinterface

interface tfla_rsp_if;
   import tfla_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [IDX_W-1:0]    granted_index;
   logic [CNT_W-1:0]    idle_count;
   logic                drained;

   modport source (output valid, output status, output granted_index,
                   output idle_count, output drained, input ready);
   modport sink (input valid, input status, input granted_index,
                 input idle_count, input drained, output ready);
endinterface

FILE: design/tfla_ram.sv
// ----------------------------------------------------------------------------
// tfla_ram
// Generic single-write, single-read synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module tfla_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port; read data holds between reads.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/tfla_sweep.sv
// ----------------------------------------------------------------------------
// tfla_sweep
// Clearing sequencer: walks every pool entry once after reset or after a new
// initial slot count, so that the ring and stamp memories take their start
// contents.
// ----------------------------------------------------------------------------
module tfla_sweep (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [tfla_pkg::CNT_W-1:0] count_n,
   output tfla_pkg::sweep_type        sweep
);
   import tfla_pkg::*;

   logic             busy_ff;
   logic             busy_in;
   logic [IDX_W-1:0] addr_ff;
   logic [IDX_W-1:0] addr_in;

   // Step through the entries, one per cycle, restarting on request.
   always_comb begin
      busy_in = busy_ff;
      addr_in = addr_ff;
      if (start) begin
         busy_in = 1'b1;
         addr_in = '0;
      end else if (busy_ff) begin
         addr_in = addr_ff + IDX_W'(1);
         if (addr_ff == IDX_W'(POOL_SIZE - 1)) begin
            busy_in = 1'b0;
            addr_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
         addr_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         addr_ff <= addr_in;
      end
   end

   // Entries below the initial count start out in the free queue.
   assign sweep.busy   = busy_ff;
   assign sweep.addr   = addr_ff;
   assign sweep.queued = ({1'b0, addr_ff} < count_n);

endmodule

FILE: design/timed_free_list_allocator.sv
// ----------------------------------------------------------------------------
// timed_free_list_allocator
// Slot allocator with a FIFO free queue and a minimum reuse delay per slot.
// ----------------------------------------------------------------------------
// An acquire reads the ring head, then that slot's stamp (S_RING, S_META); a
// release reads its stamp in S_META and a close passes S_FIN. The response
// word is registered when the final state has a free output; a response stall
// holds it there. One request word is in work at a time, so no new word is
// taken until the last one has posted its response. Reset is synchronous;
// after reset and after every initial_slots write a clearing pass over all
// 1024 entries fills the memories, and no request is taken.
// ----------------------------------------------------------------------------
module timed_free_list_allocator (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [tfla_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tfla_pkg::CSR_DATA_W-1:0] csr_wdata,
   tfla_req_if.sink                        req_bus,
   tfla_rsp_if.source                      rsp_bus
);
   import tfla_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_RING,
      S_META,
      S_FIN
   } state_type;

   state_type state_ff, state_in;

   // Control and pool registers.
   logic [DELAY_W-1:0] delay_ff, delay_in;
   logic [CNT_W-1:0]   init_n_ff, init_n_in;
   logic [IDX_W-1:0]   head_ff, head_in;
   logic [IDX_W-1:0]   tail_ff, tail_in;
   logic [CNT_W-1:0]   idle_ff, idle_in;
   logic [CNT_W-1:0]   created_ff, created_in;
   logic               closed_ff, closed_in;

   // Request word in work.
   logic [MODE_W-1:0]  mode_ff, mode_in;
   logic [STAMP_W-1:0] now_ff, now_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [IDX_W-1:0]   slot_ff, slot_in;

   // Response register.
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [IDX_W-1:0]    granted_ff, granted_in;
   logic [CNT_W-1:0]    idle_out_ff, idle_out_in;
   logic                drained_ff, drained_in;

   // Memory ports.
   logic               ring_we, ring_re;
   logic [IDX_W-1:0]   ring_waddr, ring_raddr, ring_wdata, ring_rdata;
   logic               meta_we, meta_re;
   logic [IDX_W-1:0]   meta_waddr, meta_raddr;
   logic [META_W-1:0]  meta_wdata, meta_rdata;

   sweep_type          sweep;
   logic               sweep_start;
   logic               req_accept;
   logic               out_free;
   logic [STAMP_W-1:0] head_stamp;
   logic [STAMP_W-1:0] age;
   logic               head_ready;
   logic               release_ok;

   // Free ring: slot numbers in queue order.
   tfla_ram #(.WIDTH(IDX_W), .DEPTH(POOL_SIZE)) u_ring (
      .clock   (clock),
      .wr_en   (ring_we),
      .wr_addr (ring_waddr),
      .wr_data (ring_wdata),
      .rd_en   (ring_re),
      .rd_addr (ring_raddr),
      .rd_data (ring_rdata)
   );

   // Slot metadata: queued bit over the release stamp.
   tfla_ram #(.WIDTH(META_W), .DEPTH(POOL_SIZE)) u_meta (
      .clock   (clock),
      .wr_en   (meta_we),
      .wr_addr (meta_waddr),
      .wr_data (meta_wdata),
      .rd_en   (meta_re),
      .rd_addr (meta_raddr),
      .rd_data (meta_rdata)
   );

   assign sweep_start = csr_we && (csr_index == CSR_INITIAL_SLOTS);

   tfla_sweep u_sweep (
      .clock   (clock),
      .reset   (reset),
      .start   (sweep_start),
      .count_n (init_n_ff),
      .sweep   (sweep)
   );

   // Handshakes.
   assign req_bus.ready = (state_ff == S_IDLE) && !sweep.busy;
   assign req_accept    = req_bus.valid && req_bus.ready;
   assign out_free      = !rsp_valid_ff || rsp_bus.ready;

   // Reuse test on the head slot's stamp, without wrap.
   assign head_stamp = meta_rdata[STAMP_W-1:0];
   assign age        = now_ff - head_stamp;
   assign head_ready = (head_stamp == NEVER_RELEASED) ||
                       ((now_ff >= head_stamp) && (age >= STAMP_W'(delay_ff)));

   // A release is taken for a created slot that is not already queued.
   assign release_ok = ({1'b0, idx_ff} < created_ff) && !meta_rdata[STAMP_W] &&
                       (idle_ff < CNT_W'(POOL_SIZE));

   // Next-state logic of the sequencer and the pool.
   always_comb begin
      state_in     = state_ff;
      delay_in     = delay_ff;
      init_n_in    = init_n_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      idle_in      = idle_ff;
      created_in   = created_ff;
      closed_in    = closed_ff;
      mode_in      = mode_ff;
      now_in       = now_ff;
      idx_in       = idx_ff;
      slot_in      = slot_ff;
      rsp_valid_in = rsp_valid_ff;
      status_in    = status_ff;
      granted_in   = granted_ff;
      idle_out_in  = idle_out_ff;
      drained_in   = drained_ff;
      ring_we      = 1'b0;
      ring_waddr   = tail_ff;
      ring_wdata   = idx_ff;
      ring_re      = 1'b0;
      ring_raddr   = head_ff;
      meta_we      = 1'b0;
      meta_waddr   = idx_ff;
      meta_wdata   = {1'b1, now_ff};
      meta_re      = 1'b0;
      meta_raddr   = req_bus.slot_index;

      // The waiting response word leaves.
      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               mode_in = req_bus.mode;
               now_in  = req_bus.now_ms;
               idx_in  = req_bus.slot_index;
               case (req_bus.mode)
                  MODE_ACQUIRE: begin
                     if (closed_ff) begin
                        state_in = S_FIN;
                     end else begin
                        ring_re  = 1'b1;
                        state_in = S_RING;
                     end
                  end
                  MODE_RELEASE: begin
                     meta_re  = 1'b1;
                     state_in = S_META;
                  end
                  default: begin
                     state_in = S_FIN;
                  end
               endcase
            end
         end

         // The head slot is known; fetch its stamp.
         S_RING: begin
            slot_in    = ring_rdata;
            meta_re    = 1'b1;
            meta_raddr = ring_rdata;
            state_in   = S_META;
         end

         // Decide, write back and post the response word.
         S_META: begin
            if (out_free) begin
               granted_in = '0;
               if (mode_ff == MODE_ACQUIRE) begin
                  if ((idle_ff != '0) && head_ready) begin
                     head_in    = ring_next(head_ff);
                     idle_in    = idle_ff - CNT_W'(1);
                     meta_we    = 1'b1;
                     meta_waddr = slot_ff;
                     meta_wdata = {1'b0, head_stamp};
                     granted_in = slot_ff;
                     status_in  = ST_REUSED;
                  end else if (created_ff < CNT_W'(POOL_SIZE)) begin
                     meta_we    = 1'b1;
                     meta_waddr = created_ff[IDX_W-1:0];
                     meta_wdata = {1'b0, NEVER_RELEASED};
                     created_in = created_ff + CNT_W'(1);
                     granted_in = created_ff[IDX_W-1:0];
                     status_in  = ST_CREATED;
                  end else begin
                     status_in = ST_EXHAUSTED;
                  end
               end else begin
                  if (release_ok) begin
                     meta_we    = 1'b1;
                     meta_waddr = idx_ff;
                     meta_wdata = {1'b1, now_ff};
                     ring_we    = 1'b1;
                     ring_waddr = tail_ff;
                     ring_wdata = idx_ff;
                     tail_in    = ring_next(tail_ff);
                     idle_in    = idle_ff + CNT_W'(1);
                  end
                  status_in = ST_RELEASE;
               end
               rsp_valid_in = 1'b1;
               idle_out_in  = idle_in;
               drained_in   = closed_in && (idle_in == created_in);
               state_in     = S_IDLE;
            end
         end

         // Words that need no memory access: close, refused acquire, no-op.
         S_FIN: begin
            if (out_free) begin
               granted_in = '0;
               case (mode_ff)
                  MODE_ACQUIRE: status_in = ST_CLOSED;
                  MODE_CLOSE: begin
                     closed_in = 1'b1;
                     status_in = ST_CLOSED;
                  end
                  default: status_in = ST_RELEASE;
               endcase
               rsp_valid_in = 1'b1;
               idle_out_in  = idle_ff;
               drained_in   = closed_in && (idle_ff == created_ff);
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Clearing pass owns the write ports.
      if (sweep.busy) begin
         ring_we    = 1'b1;
         ring_waddr = sweep.addr;
         ring_wdata = sweep.addr;
         meta_we    = 1'b1;
         meta_waddr = sweep.addr;
         meta_wdata = {sweep.queued, NEVER_RELEASED};
      end

      // Configuration writes.
      if (csr_we) begin
         case (csr_index)
            CSR_REUSE_DELAY: begin
               delay_in = csr_wdata[DELAY_W-1:0];
            end
            CSR_INITIAL_SLOTS: begin
               init_n_in  = clamp_initial(csr_wdata[INIT_W-1:0]);
               head_in    = '0;
               tail_in    = ring_pos(init_n_in);
               idle_in    = init_n_in;
               created_in = init_n_in;
               closed_in  = 1'b0;
               state_in   = S_IDLE;
            end
            default: begin
               delay_in = delay_ff;
            end
         endcase
      end
   end

   // State, pool registers and the response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         delay_ff     <= '0;
         init_n_ff    <= CNT_W'(MIN_INITIAL);
         head_ff      <= '0;
         tail_ff      <= ring_pos(CNT_W'(MIN_INITIAL));
         idle_ff      <= CNT_W'(MIN_INITIAL);
         created_ff   <= CNT_W'(MIN_INITIAL);
         closed_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         delay_ff     <= delay_in;
         init_n_ff    <= init_n_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         idle_ff      <= idle_in;
         created_ff   <= created_in;
         closed_ff    <= closed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mode_ff     <= mode_in;
      now_ff      <= now_in;
      idx_ff      <= idx_in;
      slot_ff     <= slot_in;
      status_ff   <= status_in;
      granted_ff  <= granted_in;
      idle_out_ff <= idle_out_in;
      drained_ff  <= drained_in;
   end

   // Response channel.
   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.status        = status_ff;
   assign rsp_bus.granted_index = granted_ff;
   assign rsp_bus.idle_count    = idle_out_ff;
   assign rsp_bus.drained       = drained_ff;

endmodule
